@@ hw/rtl/pctb_pkg.sv @@
// Shared types and codes for the periodic countdown timer bank.
package pctb_pkg;

    localparam int IDX_W   = 4;
    localparam int CNT_W   = 16;
    localparam int MINUTE_W = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] OP_ADD_SEC = 2'd0;
    localparam logic [1:0] OP_ADD_MIN = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_REG    = 2'd1;
    localparam logic [1:0] ST_OTHER_KIND = 2'd2;

    localparam logic KIND_FIRE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] period;
    } t_entry;

    typedef struct packed {
        logic             result_kind;
        logic [IDX_W-1:0] fired_slot;
        logic             fired_is_minute;
        logic [1:0]       status;
        logic [CNT_W-1:0] next_due_seconds;
        logic             seconds_idle;
        logic             minutes_active;
        logic             last;
    } t_result;

endpackage

@@ hw/rtl/pctb_slot_mem.sv @@
// Count and period store: one write port, one read port, registered read data.
module pctb_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pctb_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output pctb_pkg::t_entry o_rdata
);
    import pctb_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pctb_out_reg.sv @@
// Result output register: holds one beat until the consumer takes it.
module pctb_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pctb_pkg::t_result i_beat,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output pctb_pkg::t_result o_beat
);
    import pctb_pkg::*;

    logic    r_valid;
    t_result r_beat;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

endmodule

@@ hw/rtl/periodic_countdown_timer_bank_unit.sv @@
// Flow: an item is taken in S_IDLE; each pass over the slot store is S_LOAD, then S_WALK over
// N = min(SLOTS,16) slots, one slot per cycle from the read port while no fired beat waits on
// a full output register; a tick with a minute change adds a second pass, over the minutes
// slots, then S_SUM sends the summary. No new item is taken until the summary is loaded.
// Reset (synchronous, active low) clears the slot flags, the minute tracker and the control;
// the count/period store is not cleared and is written as a slot turns active.
module periodic_countdown_timer_bank_unit #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [pctb_pkg::IDX_W-1:0]    i_slot_index,
    input  logic [pctb_pkg::CNT_W-1:0]    i_period,
    input  logic [pctb_pkg::CNT_W-1:0]    i_pad_seconds,
    input  logic [pctb_pkg::CNT_W-1:0]    i_elapsed_seconds,
    input  logic [pctb_pkg::MINUTE_W-1:0] i_current_minute,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_result_kind,
    output logic [pctb_pkg::IDX_W-1:0]    o_fired_slot,
    output logic                          o_fired_is_minute,
    output logic [1:0]                    o_status,
    output logic [pctb_pkg::CNT_W-1:0]    o_next_due_seconds,
    output logic                          o_seconds_idle,
    output logic                          o_minutes_active,
    output logic                          o_last
);
    import pctb_pkg::*;

    localparam int NSLOT = (SLOTS < (1 << IDX_W)) ? SLOTS : (1 << IDX_W);
    localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(NSLOT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_SUM  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [NSLOT-1:0]    r_active, n_active;
    logic [NSLOT-1:0]    r_is_min, n_is_min;
    logic [MINUTE_W-1:0] r_last_minute, n_last_minute;
    logic                r_minute_seen, n_minute_seen;
    logic                r_mcredit, n_mcredit;
    logic                r_pass, n_pass;
    logic                r_tick, n_tick;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_elapsed, n_elapsed;
    logic [CNT_W-1:0]    r_due, n_due;
    logic [1:0]          r_status, n_status;

    logic          in_acc;
    logic [AW-1:0] sidx;
    logic          idx_out;
    logic          want_min;
    logic [CNT_W:0] pad_sum;
    logic [CNT_W-1:0] add_count;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, mem_rdata;

    logic             sel, credit_en, do_credit, fire, blocked;
    logic [CNT_W-1:0] amt, cnt, newc, post_c, due_cand;

    logic    out_load, out_free;
    t_result out_beat, out_q;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign sidx     = i_slot_index[AW-1:0];
    assign idx_out  = (int'(i_slot_index) >= SLOTS);
    assign want_min = (i_operation == OP_ADD_MIN);
    assign pad_sum  = {1'b0, i_period} + {1'b0, i_pad_seconds};
    assign add_count = want_min ? i_period : (pad_sum[CNT_W] ? COUNT_MAX : pad_sum[CNT_W-1:0]);

    // Slot under the walk: pass 0 visits seconds slots, pass 1 minutes slots.
    assign cnt       = mem_rdata.count;
    assign sel       = r_active[r_ptr] && (r_is_min[r_ptr] == r_pass);
    assign credit_en = r_pass ? 1'b1 : (r_tick && (r_elapsed != '0));
    assign amt       = r_pass ? CNT_W'(1) : r_elapsed;
    assign do_credit = sel && credit_en;
    assign newc      = (amt < cnt) ? (cnt - amt) : '0;
    assign fire      = do_credit && (newc == '0);
    assign post_c    = do_credit ? (fire ? mem_rdata.period : newc) : cnt;
    assign due_cand  = (post_c == '0) ? CNT_W'(1) : post_c;
    assign blocked   = fire && !out_free;

    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_is_min      = r_is_min;
        n_last_minute = r_last_minute;
        n_minute_seen = r_minute_seen;
        n_mcredit     = r_mcredit;
        n_pass        = r_pass;
        n_tick        = r_tick;
        n_ptr         = r_ptr;
        n_elapsed     = r_elapsed;
        n_due         = r_due;
        n_status      = r_status;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        out_load      = 1'b0;
        out_beat      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_tick    = (i_operation == OP_TICK);
                    n_elapsed = i_elapsed_seconds;
                    n_status  = ST_OK;
                    n_due     = COUNT_MAX;
                    n_pass    = 1'b0;
                    n_mcredit = 1'b0;
                    n_state   = S_LOAD;
                    if (i_operation == OP_TICK) begin
                        if (!r_minute_seen) begin
                            n_last_minute = i_current_minute;
                            n_minute_seen = 1'b1;
                        end else if (r_last_minute != i_current_minute) begin
                            n_last_minute = i_current_minute;
                            n_mcredit     = 1'b1;
                        end
                    end else if (idx_out) begin
                        n_status = ST_NOT_REG;
                    end else if (i_operation == OP_REMOVE) begin
                        if (!r_active[sidx]) begin
                            n_status = ST_NOT_REG;
                        end else begin
                            n_active[sidx] = 1'b0;
                        end
                    end else if (r_active[sidx] && (r_is_min[sidx] != want_min)) begin
                        n_status = ST_OTHER_KIND;
                    end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = sidx;
                        mem_wdata.count  = add_count;
                        mem_wdata.period = i_period;
                        n_active[sidx]   = 1'b1;
                        n_is_min[sidx]   = want_min;
                    end
                end
            end
            S_LOAD: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_ptr     = '0;
                n_state   = S_WALK;
            end
            S_WALK: begin
                // Hold the slot while its fired beat cannot go out.
                if (!blocked) begin
                    if (do_credit) begin
                        mem_we           = 1'b1;
                        mem_waddr        = r_ptr;
                        mem_wdata.count  = post_c;
                        mem_wdata.period = mem_rdata.period;
                    end
                    if (fire) begin
                        out_load                 = 1'b1;
                        out_beat.result_kind     = KIND_FIRE;
                        out_beat.fired_slot      = IDX_W'(r_ptr);
                        out_beat.fired_is_minute = r_pass;
                    end
                    if (!r_pass && sel && (due_cand < r_due)) begin
                        n_due = due_cand;
                    end
                    if (r_ptr == LAST_SLOT) begin
                        if (!r_pass && r_mcredit) begin
                            n_pass  = 1'b1;
                            n_state = S_LOAD;
                        end else begin
                            n_state = S_SUM;
                        end
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_ptr + 1'b1;
                        n_ptr     = r_ptr + 1'b1;
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    out_beat.result_kind      = KIND_SUMMARY;
                    out_beat.status           = r_status;
                    out_beat.next_due_seconds = r_due;
                    out_beat.seconds_idle     = ~|(r_active & ~r_is_min);
                    out_beat.minutes_active   = |(r_active & r_is_min);
                    out_beat.last             = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active      <= '0;
            r_is_min      <= '0;
            r_last_minute <= '0;
            r_minute_seen <= 1'b0;
            r_mcredit     <= 1'b0;
            r_pass        <= 1'b0;
            r_tick        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_is_min      <= n_is_min;
            r_last_minute <= n_last_minute;
            r_minute_seen <= n_minute_seen;
            r_mcredit     <= n_mcredit;
            r_pass        <= n_pass;
            r_tick        <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_elapsed <= n_elapsed;
        r_due     <= n_due;
        r_status  <= n_status;
    end

    pctb_slot_mem #(
        .DEPTH (NSLOT),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pctb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_beat  (out_beat),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_free  (out_free),
        .o_beat  (out_q)
    );

    assign o_result_kind      = out_q.result_kind;
    assign o_fired_slot       = out_q.fired_slot;
    assign o_fired_is_minute  = out_q.fired_is_minute;
    assign o_status           = out_q.status;
    assign o_next_due_seconds = out_q.next_due_seconds;
    assign o_seconds_idle     = out_q.seconds_idle;
    assign o_minutes_active   = out_q.minutes_active;
    assign o_last             = out_q.last;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output beat loaded over an untaken beat");

    a_minute_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> (r_mcredit && r_tick))
        else $error("minute pass without a minute change");

    a_wb_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_WALK)) |-> r_active[r_ptr])
        else $error("write-back to an inactive slot");

    a_summary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && out_free) |=> ((r_state == S_IDLE) && o_valid && o_last))
        else $error("summary beat not presented");
`endif

endmodule
